/* rtl/cee_pkg.sv */
// Shared widths, configuration types and helpers of the colour envelope evaluator.
package cee_pkg;

  // Field widths.
  localparam int ChanW   = 8;
  localparam int NumChan = 3;
  localparam int ColorW  = ChanW * NumChan;
  localparam int PointW  = 16;
  localparam int CfgIdxW = 3;

  // Ramp arithmetic: product of colour step and offset, quotient of one channel.
  localparam int ProdW           = ChanW + PointW;
  localparam int QuoW            = ChanW;
  localparam int DivBitsPerStage = 2;
  localparam int NumDivStages    = QuoW / DivBitsPerStage;

  // Select stage, multiply stage, then the divider stages, the last of which
  // also forms the final channel value.
  localparam int Latency = NumDivStages + 2;

  // Reset values of the configuration registers.
  localparam logic [PointW-1:0] PeakPointReset = PointW'(32768);
  localparam logic [PointW-1:0] OutPointReset  = PointW'(65535);

  typedef enum logic [CfgIdxW-1:0] {
    RegStartColor  = 3'd0,
    RegPeakColor   = 3'd1,
    RegEndColor    = 3'd2,
    RegInPoint     = 3'd3,
    RegPeakPoint   = 3'd4,
    RegOutPoint    = 3'd5,
    RegInterpolate = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [ColorW-1:0] start_color;
    logic [ColorW-1:0] peak_color;
    logic [ColorW-1:0] end_color;
    logic [PointW-1:0] in_point;
    logic [PointW-1:0] peak_point;
    logic [PointW-1:0] out_point;
    logic              interpolate;
  } cfg_t;

  // Per-channel operands of a ramp: base value, magnitude and sign of the step.
  typedef struct packed {
    logic [ChanW-1:0] base;
    logic [ChanW-1:0] mag;
    logic             neg;
  } chan_op_t;

  // Channel c of a packed colour, red being channel 0 in the top byte.
  function automatic logic [ChanW-1:0] chan_of(input logic [ColorW-1:0] rgb, input int c);
    logic [ColorW-1:0] s;
    s = rgb >> (ChanW * (NumChan - 1 - c));
    return s[ChanW-1:0];
  endfunction

endpackage

/* rtl/color_envelope_evaluator_top.sv */
// Colour envelope evaluator: maps a particle's life fraction to an RGB colour.
//
// Usage: configuration registers are written over the cfg channel (index,
// data, valid/ready); the port is always ready and takes one write per cycle.
// Registers should only be written while no item is in flight.
// A life fraction enters on the input channel when in_valid_i is high and
// in_stall_o is low; exactly one colour leaves on the output channel for it,
// transferred when out_valid_o is high and out_stall_i is low.
// From input transfer to out_valid_o an item passes one select
// stage, one multiply stage and four divider stages of two quotient bits,
// the last of which also adds the signed quotient to the base channel.
// Throughput is one item per cycle when not stalled (divider fully pipelined).
// While a result waits under out_stall_i the whole pipeline holds and
// in_stall_o is raised; nothing is lost or repeated.
// Reset clears the pipeline valid bits and loads the register defaults:
// black colours, in point 0, peak point one half, out point full scale,
// interpolation on.
module color_envelope_evaluator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cee_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cee_pkg::ColorW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cee_pkg::PointW-1:0]   life_rate_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cee_pkg::ChanW-1:0]    red_o,
  output logic [cee_pkg::ChanW-1:0]    green_o,
  output logic [cee_pkg::ChanW-1:0]    blue_o
);
  import cee_pkg::*;

  cfg_t                          cfg_q;
  logic                          en;
  logic [Latency-1:0]            valid_q;
  chan_op_t [NumChan-1:0]        s1_op;
  logic [PointW-1:0]             s1_num;
  logic [PointW-1:0]             s1_den;
  logic [NumChan-1:0][ChanW-1:0] res;

  // Configuration registers; writes to an unknown index are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_color <= '0;
      cfg_q.peak_color  <= '0;
      cfg_q.end_color   <= '0;
      cfg_q.in_point    <= '0;
      cfg_q.peak_point  <= PeakPointReset;
      cfg_q.out_point   <= OutPointReset;
      cfg_q.interpolate <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegStartColor:  cfg_q.start_color <= cfg_data_i;
        RegPeakColor:   cfg_q.peak_color  <= cfg_data_i;
        RegEndColor:    cfg_q.end_color   <= cfg_data_i;
        RegInPoint:     cfg_q.in_point    <= cfg_data_i[PointW-1:0];
        RegPeakPoint:   cfg_q.peak_point  <= cfg_data_i[PointW-1:0];
        RegOutPoint:    cfg_q.out_point   <= cfg_data_i[PointW-1:0];
        RegInterpolate: cfg_q.interpolate <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[Latency-2:0], in_valid_i};
    end
  end

  assign out_valid_o = valid_q[Latency-1];

  // Segment selection.
  cee_select u_select (
    .clk_i       (clk_i),
    .en_i        (en),
    .life_rate_i (life_rate_i),
    .cfg_i       (cfg_q),
    .op_o        (s1_op),
    .num_o       (s1_num),
    .den_o       (s1_den)
  );

  // One multiply and divide lane per colour channel.
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    cee_channel u_channel (
      .clk_i (clk_i),
      .en_i  (en),
      .op_i  (s1_op[c]),
      .num_i (s1_num),
      .den_i (s1_den),
      .res_o (res[c])
    );
  end

  assign red_o   = res[0];
  assign green_o = res[1];
  assign blue_o  = res[2];

`ifndef ASSERT_OFF
  // The input is only held off when a result is waiting on the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A held pipeline keeps its occupancy.
  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid_q))
    else $error("pipeline occupancy changed during a stall");

  // Every item in the select stage carries a positive divisor.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (s1_den != '0))
    else $error("zero divisor in the ramp");
`endif

endmodule

/* rtl/cee_select.sv */
// Segment selection stage: picks the keys and forms ramp operands for each channel.
module cee_select (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [cee_pkg::PointW-1:0]               life_rate_i,
  input  cee_pkg::cfg_t                            cfg_i,
  output cee_pkg::chan_op_t [cee_pkg::NumChan-1:0] op_o,
  output logic [cee_pkg::PointW-1:0]               num_o,
  output logic [cee_pkg::PointW-1:0]               den_o
);
  import cee_pkg::*;

  logic                        ramp;
  logic [ColorW-1:0]           col_a;
  logic [ColorW-1:0]           col_b;
  logic [PointW-1:0]           lo;
  logic [PointW-1:0]           hi;
  chan_op_t [NumChan-1:0]      op_d;
  chan_op_t [NumChan-1:0]      op_q;
  logic [PointW-1:0]           num_d;
  logic [PointW-1:0]           num_q;
  logic [PointW-1:0]           den_d;
  logic [PointW-1:0]           den_q;

  // Keys are compared in order; a segment is only entered when lo <= t < hi.
  always_comb begin
    ramp  = 1'b0;
    col_a = cfg_i.end_color;
    col_b = cfg_i.end_color;
    lo    = '0;
    hi    = '0;
    if (life_rate_i < cfg_i.in_point) begin
      col_a = cfg_i.start_color;
    end else if (life_rate_i < cfg_i.peak_point) begin
      if (cfg_i.interpolate) begin
        ramp  = 1'b1;
        col_a = cfg_i.start_color;
        col_b = cfg_i.peak_color;
        lo    = cfg_i.in_point;
        hi    = cfg_i.peak_point;
      end else begin
        col_a = cfg_i.peak_color;
      end
    end else if (life_rate_i < cfg_i.out_point) begin
      if (cfg_i.interpolate) begin
        ramp  = 1'b1;
        col_a = cfg_i.peak_color;
        col_b = cfg_i.end_color;
        lo    = cfg_i.peak_point;
        hi    = cfg_i.out_point;
      end
    end
  end

  // A held colour is a ramp with a zero step over a unit divisor.
  assign num_d = ramp ? (life_rate_i - lo) : '0;
  assign den_d = ramp ? (hi - lo) : PointW'(1);

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    logic [ChanW-1:0]        a;
    logic [ChanW-1:0]        b;
    logic signed [ChanW:0]   diff;
    logic [ChanW:0]          diff_neg;
    logic [ChanW-1:0]        mag;

    assign a        = chan_of(col_a, c);
    assign b        = chan_of(col_b, c);
    assign diff     = $signed({1'b0, b}) - $signed({1'b0, a});
    assign diff_neg = -diff;
    assign mag      = !ramp ? '0 : (diff[ChanW] ? diff_neg[ChanW-1:0] : diff[ChanW-1:0]);
    assign op_d[c]  = '{base: a, mag: mag, neg: ramp & diff[ChanW]};
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q  <= op_d;
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  assign op_o  = op_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

/* rtl/cee_channel.sv */
// One colour channel: step multiply, pipelined restoring divide and final add.
module cee_channel (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  cee_pkg::chan_op_t           op_i,
  input  logic [cee_pkg::PointW-1:0]  num_i,
  input  logic [cee_pkg::PointW-1:0]  den_i,
  output logic [cee_pkg::ChanW-1:0]   res_o
);
  import cee_pkg::*;

  localparam int Last = NumDivStages - 1;

  // Multiply stage.
  logic [ProdW-1:0]  prod_q;
  logic [PointW-1:0] den_m_q;
  logic [ChanW-1:0]  base_m_q;
  logic              neg_m_q;

  // Registers between divider stages.
  logic [ProdW-1:0]  rem_q  [Last];
  logic [QuoW-1:0]   quo_q  [Last];
  logic [PointW-1:0] den_q  [Last];
  logic [ChanW-1:0]  base_q [Last];
  logic              neg_q  [Last];

  logic [ChanW-1:0]  res_q;

  // The product stays below 256 times the divisor, so eight quotient bits suffice.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= ProdW'(op_i.mag) * ProdW'(num_i);
      den_m_q  <= den_i;
      base_m_q <= op_i.base;
      neg_m_q  <= op_i.neg;
    end
  end

  for (genvar s = 0; s < NumDivStages; s++) begin : g_div
    logic [ProdW-1:0]  rem_in;
    logic [QuoW-1:0]   quo_in;
    logic [PointW-1:0] den_in;
    logic [ChanW-1:0]  base_in;
    logic              neg_in;
    logic [ProdW-1:0]  rem_d;
    logic [QuoW-1:0]   quo_d;

    if (s == 0) begin : g_first
      assign rem_in  = prod_q;
      assign quo_in  = '0;
      assign den_in  = den_m_q;
      assign base_in = base_m_q;
      assign neg_in  = neg_m_q;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign base_in = base_q[s-1];
      assign neg_in  = neg_q[s-1];
    end

    // Restoring division, most significant quotient bits first.
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < DivBitsPerStage; j++) begin
        if (rem_d >= (ProdW'(den_in) << (QuoW - 1 - s * DivBitsPerStage - j))) begin
          rem_d = rem_d - (ProdW'(den_in) << (QuoW - 1 - s * DivBitsPerStage - j));
          quo_d = quo_d | (QuoW'(1) << (QuoW - 1 - s * DivBitsPerStage - j));
        end
      end
    end

    if (s < Last) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s]  <= rem_d;
          quo_q[s]  <= quo_d;
          den_q[s]  <= den_in;
          base_q[s] <= base_in;
          neg_q[s]  <= neg_in;
        end
      end
    end else begin : g_out
      // The quotient is truncated toward zero, then applied with the step's sign.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          res_q <= neg_in ? (base_in - quo_d) : (base_in + quo_d);
        end
      end
    end
  end

  assign res_o = res_q;

endmodule
